FILE: src/ler_pkg.sv
// shared types and codes for the line editing receive ring
`timescale 1ns / 1ps

package ler_pkg;

   // request kinds on req_tuser
   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // result kinds on rsp_tuser
   localparam logic [1:0] KIND_ECHO    = 2'd0;
   localparam logic [1:0] KIND_CHAR    = 2'd1;
   localparam logic [1:0] KIND_LEN     = 2'd2;
   localparam logic [1:0] KIND_NO_LINE = 2'd3;

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TOP = 8'h7E;
   localparam logic [7:0] CH_DEL = 8'h7F;

   localparam logic [4:0] MAX_LINE_CHARS = 5'd31;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic       last;
      logic [5:0] line_length;
      logic [5:0] fill_count;
      logic [5:0] lines_pending;
   } rsp_word_type;

endpackage

FILE: src/line_editing_receive_ring.sv
// Line editing receive ring: received bytes are echoed and edited into a circular
// character memory (one write port, one read port, registered read data); read
// requests remove the oldest line. One request is handled at a time. A printable
// byte or line end is stored at once, or, when the memory is full, after the oldest
// entry is checked for a line end, then echoed one word per cycle unless stalled;
// an erase reads the previous entry and, unless it is a line end, removes it with
// three echo words. A line read scans entries up to the line end, then walks the
// same entries again while delivering characters, and ends with the length word;
// with no line pending or a zero max_len it answers with a single word. Output
// words wait in a single result register while the consumer stalls.
`timescale 1ns / 1ps

module line_editing_receive_ring
   import ler_pkg::*;
#(
   parameter int STORE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], max_len[15:8]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // char_out[7:0], line_length[13:8],
                                    // fill_count[19:14], lines_pending[25:20], zero
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   localparam int PTR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERASE_CHK, ST_DROP_CHK, ST_ECHO, ST_NO_LINE,
      ST_SCAN_RD, ST_SCAN_CHK, ST_EMIT_RD, ST_EMIT_CHK, ST_LEN
   } state_type;

   typedef enum logic [1:0] {
      ECHO_ONE, ECHO_CRLF, ECHO_ERASE
   } echo_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      ptr_prev = (p == '0) ? PTR_W'(STORE_DEPTH - 1) : p - 1'b1;
   endfunction

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0]   rd_pos_ff, rd_pos_in;
   logic [PTR_W-1:0]   walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]   lines_ff, lines_in;
   logic               after_cr_ff, after_cr_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   nchar_ff, nchar_in;
   logic [4:0]         got_ff, got_in;
   logic [7:0]         max_len_ff, max_len_in;
   logic [6:0]         pend_char_ff, pend_char_in;
   logic               pend_cr_ff, pend_cr_in;
   echo_type           echo_seq_ff, echo_seq_in;
   logic [1:0]         echo_step_ff, echo_step_in;
   rsp_word_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [6:0]         store_mem [STORE_DEPTH];
   logic [6:0]         rd_data_ff;
   logic               mem_we, mem_re;
   logic [PTR_W-1:0]   mem_waddr, mem_raddr;
   logic [6:0]         mem_wdata;

   logic               out_free;
   logic               req_fire;
   logic [7:0]         rx_byte;
   logic [7:0]         req_max_len;
   logic               take_char;
   logic               scan_cr;
   logic [CNT_W-1:0]   scan_cnt;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign rx_byte     = req_tdata[7:0];
   assign req_max_len = req_tdata[15:8];
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign take_char   = ({3'b000, got_ff} + 8'd1 < max_len_ff) && (got_ff < MAX_LINE_CHARS);
   assign scan_cr     = (rd_data_ff == CH_CR[6:0]);
   assign scan_cnt    = idx_ff + 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {6'b000000, rsp_ff.lines_pending, rsp_ff.fill_count,
                        rsp_ff.line_length, rsp_ff.char_out};

   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      walk_ptr_in  = walk_ptr_ff;
      held_in      = held_ff;
      lines_in     = lines_ff;
      after_cr_in  = after_cr_ff;
      idx_in       = idx_ff;
      nchar_in     = nchar_ff;
      got_in       = got_ff;
      max_len_in   = max_len_ff;
      pend_char_in = pend_char_ff;
      pend_cr_in   = pend_cr_ff;
      echo_seq_in  = echo_seq_ff;
      echo_step_in = echo_step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_waddr    = wr_pos_ff;
      mem_wdata    = pend_char_ff;
      mem_re       = 1'b0;
      mem_raddr    = walk_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  REQ_BYTE: begin
                     priority if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
                        after_cr_in = 1'b0;
                        if (held_ff != '0) begin
                           mem_re    = 1'b1;
                           mem_raddr = ptr_prev(wr_pos_ff);
                           state_in  = ST_ERASE_CHK;
                        end
                     end else if (rx_byte == CH_LF && after_cr_ff) begin
                        after_cr_in = 1'b0;
                     end else if (rx_byte == CH_LF || rx_byte == CH_CR
                                  || (rx_byte >= CH_SP && rx_byte <= CH_TOP)) begin
                        // bare lf is taken as cr
                        pend_cr_in   = (rx_byte == CH_LF || rx_byte == CH_CR);
                        pend_char_in = (rx_byte == CH_LF) ? CH_CR[6:0] : rx_byte[6:0];
                        echo_seq_in  = (rx_byte == CH_LF || rx_byte == CH_CR)
                                       ? ECHO_CRLF : ECHO_ONE;
                        echo_step_in = 2'd0;
                        if (held_ff == CNT_W'(STORE_DEPTH)) begin
                           mem_re    = 1'b1;
                           mem_raddr = rd_pos_ff;
                           state_in  = ST_DROP_CHK;
                        end else begin
                           mem_we      = 1'b1;
                           mem_waddr   = wr_pos_ff;
                           mem_wdata   = (rx_byte == CH_LF) ? CH_CR[6:0] : rx_byte[6:0];
                           wr_pos_in   = ptr_next(wr_pos_ff);
                           held_in     = held_ff + 1'b1;
                           after_cr_in = (rx_byte == CH_LF || rx_byte == CH_CR);
                           if (rx_byte == CH_LF || rx_byte == CH_CR) begin
                              lines_in = lines_ff + 1'b1;
                           end
                           state_in = ST_ECHO;
                        end
                     end else begin
                        // control bytes are dropped
                        state_in = ST_IDLE;
                     end
                  end
                  REQ_READ: begin
                     max_len_in = req_max_len;
                     if (lines_ff == '0 || req_max_len == 8'd0) begin
                        state_in = ST_NO_LINE;
                     end else begin
                        walk_ptr_in = rd_pos_ff;
                        idx_in      = '0;
                        state_in    = ST_SCAN_RD;
                     end
                  end
                  REQ_CLEAR: begin
                     wr_pos_in   = '0;
                     rd_pos_in   = '0;
                     held_in     = '0;
                     lines_in    = '0;
                     after_cr_in = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ERASE_CHK: begin
            if (rd_data_ff != CH_CR[6:0]) begin
               wr_pos_in    = ptr_prev(wr_pos_ff);
               held_in      = held_ff - 1'b1;
               echo_seq_in  = ECHO_ERASE;
               echo_step_in = 2'd0;
               state_in     = ST_ECHO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DROP_CHK: begin
            // oldest entry gives way; held count stays at depth
            mem_we      = 1'b1;
            mem_waddr   = wr_pos_ff;
            mem_wdata   = pend_char_ff;
            wr_pos_in   = ptr_next(wr_pos_ff);
            rd_pos_in   = ptr_next(rd_pos_ff);
            after_cr_in = pend_cr_ff;
            lines_in    = lines_ff - CNT_W'(scan_cr && lines_ff != '0) + CNT_W'(pend_cr_ff);
            state_in    = ST_ECHO;
         end
         ST_ECHO: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = KIND_ECHO;
               rsp_in.line_length   = '0;
               rsp_in.fill_count    = 6'(held_ff);
               rsp_in.lines_pending = 6'(lines_ff);
               unique case (echo_seq_ff)
                  ECHO_ONE: begin
                     rsp_in.char_out = {1'b0, pend_char_ff};
                     rsp_in.last     = 1'b1;
                  end
                  ECHO_CRLF: begin
                     rsp_in.char_out = (echo_step_ff == 2'd0) ? CH_CR : CH_LF;
                     rsp_in.last     = (echo_step_ff == 2'd1);
                  end
                  default: begin
                     rsp_in.char_out = (echo_step_ff == 2'd1) ? CH_SP : CH_BS;
                     rsp_in.last     = (echo_step_ff == 2'd2);
                  end
               endcase
               echo_step_in = echo_step_ff + 1'b1;
               if (rsp_in.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NO_LINE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = KIND_NO_LINE;
               rsp_in.char_out      = '0;
               rsp_in.last          = 1'b1;
               rsp_in.line_length   = '0;
               rsp_in.fill_count    = 6'(held_ff);
               rsp_in.lines_pending = 6'(lines_ff);
               state_in             = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = walk_ptr_ff;
            state_in  = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (scan_cr || scan_cnt == held_ff) begin
               // line extent known: commit counts, then walk it again to deliver
               held_in     = held_ff - scan_cnt;
               lines_in    = scan_cr ? lines_ff - 1'b1 : '0;
               nchar_in    = scan_cr ? idx_ff : scan_cnt;
               rd_pos_in   = ptr_next(walk_ptr_ff);
               walk_ptr_in = rd_pos_ff;
               idx_in      = '0;
               got_in      = '0;
               state_in    = ST_EMIT_RD;
            end else begin
               walk_ptr_in = ptr_next(walk_ptr_ff);
               idx_in      = scan_cnt;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            if (idx_ff == nchar_ff) begin
               state_in = ST_LEN;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = walk_ptr_ff;
               state_in  = ST_EMIT_CHK;
            end
         end
         ST_EMIT_CHK: begin
            if (!take_char || out_free) begin
               if (take_char) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.kind          = KIND_CHAR;
                  rsp_in.char_out      = {1'b0, rd_data_ff};
                  rsp_in.last          = 1'b0;
                  rsp_in.line_length   = '0;
                  rsp_in.fill_count    = 6'(held_ff);
                  rsp_in.lines_pending = 6'(lines_ff);
                  got_in               = got_ff + 1'b1;
               end
               idx_in      = idx_ff + 1'b1;
               walk_ptr_in = ptr_next(walk_ptr_ff);
               state_in    = ST_EMIT_RD;
            end
         end
         ST_LEN: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = KIND_LEN;
               rsp_in.char_out      = '0;
               rsp_in.last          = 1'b1;
               rsp_in.line_length   = {1'b0, got_ff};
               rsp_in.fill_count    = 6'(held_ff);
               rsp_in.lines_pending = 6'(lines_ff);
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         held_ff      <= '0;
         lines_ff     <= '0;
         after_cr_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         held_ff      <= held_in;
         lines_ff     <= lines_in;
         after_cr_ff  <= after_cr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ptr_ff  <= walk_ptr_in;
      idx_ff       <= idx_in;
      nchar_ff     <= nchar_in;
      got_ff       <= got_in;
      max_len_ff   <= max_len_in;
      pend_char_ff <= pend_char_in;
      pend_cr_ff   <= pend_cr_in;
      echo_seq_ff  <= echo_seq_in;
      echo_step_ff <= echo_step_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(STORE_DEPTH))
      else $error("held count above store depth");

   lines_within_held: assert property (@(posedge clock) disable iff (reset)
      lines_ff <= held_ff)
      else $error("more pending lines than held characters");

   clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == REQ_CLEAR |=> held_ff == '0 && lines_ff == '0)
      else $error("clear left characters behind");

   line_char_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_CHAR |-> !rsp_ff.last)
      else $error("line character word marked last");

endmodule
